[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KBPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define KBPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kbpd_pkg.sv]
`default_nettype none

package kbpd_pkg;

  localparam int unsigned SPEED_W = 12;
  localparam int unsigned CMD_W   = 13;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned ACC_W   = 21;
  localparam int unsigned THR_W   = SPEED_W + LEN_W;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned SPEED_MAX = 4095;
  localparam int unsigned BURST_MAX = 255;

  localparam logic [POS_W-1:0] POS_LIMIT = '1;

  typedef enum logic [ADDR_W-1:0] {
    REG_FLOOR_SPEED  = 8'd0,
    REG_BOOST_SPEED  = 8'd1,
    REG_BURST_LENGTH = 8'd2,
    REG_KICK_LENGTH  = 8'd3
  } kbpd_reg_e;

  typedef struct packed {
    logic [SPEED_W-1:0] floor_speed;
    logic [SPEED_W-1:0] boost_speed;
    logic [LEN_W-1:0]   burst_length;
    logic [LEN_W-1:0]   kick_length;
  } kbpd_cfg_t;

endpackage

`default_nettype wire

[rtl/kick_burst_pulse_drive.sv]
`default_nettype none

// Two-wheel kick and burst pulse drive. One input word per clock carries the
// left and right desired speeds; the matching command word appears in the
// next cycle from an output register; a new word is taken every cycle while
// the output side keeps up (the output register alone sets the rate). Both
// wheels are handled by identical lanes updated in the same cycle. Any write
// to a listed configuration register clears the state of both wheels; write
// configuration only while no word is in flight.

module kick_burst_pulse_drive
  import kbpd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [12:0] left_desired, [25:13] right_desired, [31:26] zero
  input  wire logic [DATA_W-1:0] s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // [12:0] left_command, [25:13] right_command, [31:26] zero
  output logic [DATA_W-1:0]      m_axis_tdata_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [ADDR_W-1:0] cfg_addr_i,
  input  wire logic [DATA_W-1:0] cfg_data_i
);

  kbpd_cfg_t cfg_q, cfg_d;
  logic      cfg_hit;
  logic      step;
  logic signed [CMD_W-1:0] cmd [2];

  assign cfg_ready_o = 1'b1;
  assign step        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b0;
    case (cfg_addr_i)
      REG_FLOOR_SPEED: begin
        cfg_d.floor_speed = cfg_data_i[SPEED_W-1:0];
        cfg_hit           = 1'b1;
      end
      REG_BOOST_SPEED: begin
        cfg_d.boost_speed = cfg_data_i[SPEED_W-1:0];
        cfg_hit           = 1'b1;
      end
      REG_BURST_LENGTH: begin
        cfg_d.burst_length = cfg_data_i[LEN_W-1:0];
        cfg_hit            = 1'b1;
      end
      REG_KICK_LENGTH: begin
        cfg_d.kick_length = cfg_data_i[LEN_W-1:0];
        cfg_hit           = 1'b1;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_speed  <= SPEED_W'(1);
      cfg_q.boost_speed  <= SPEED_W'(4095);
      cfg_q.burst_length <= LEN_W'(6);
      cfg_q.kick_length  <= LEN_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_d;
    end
  end

  for (genvar w = 0; w < 2; w++) begin : g_lane
    kbpd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg_q),
      .step_i    (step),
      .clear_i   (cfg_valid_i && cfg_ready_o && cfg_hit),
      .desired_i (s_axis_tdata_i[w*CMD_W +: CMD_W]),
      .command_o (cmd[w])
    );
  end

  kbpd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s_axis_tvalid_i),
    .left_i        (cmd[0]),
    .right_i       (cmd[1]),
    .ready_o       (s_axis_tready_o),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

[rtl/kbpd_lane.sv]
`default_nettype none

`include "assert_macros.svh"

module kbpd_lane
  import kbpd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire kbpd_cfg_t               cfg_i,
  input  wire logic                    step_i,
  input  wire logic                    clear_i,
  input  wire logic [CMD_W-1:0]        desired_i,
  output logic signed [CMD_W-1:0]      command_o
);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   brem_q, brem_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  logic               neg;
  logic [CMD_W-1:0]   mag_raw;
  logic [SPEED_W-1:0] mag;
  logic [LEN_W-1:0]   burst;
  logic [THR_W-1:0]   threshold;
  logic [ACC_W-1:0]   acc_sum;
  logic               fire;
  logic               on;
  logic [SPEED_W-1:0] level;
  logic [POS_W-1:0]   pos_inc;

  assign neg     = desired_i[CMD_W-1];
  assign mag_raw = neg ? CMD_W'(-desired_i) : desired_i;
  assign mag     = (32'(mag_raw) > SPEED_MAX) ? SPEED_W'(SPEED_MAX) : mag_raw[SPEED_W-1:0];

  always_comb begin
    if (cfg_i.burst_length == '0) begin
      burst = LEN_W'(1);
    end else if (32'(cfg_i.burst_length) > BURST_MAX) begin
      burst = LEN_W'(BURST_MAX);
    end else begin
      burst = cfg_i.burst_length;
    end
  end

  assign threshold = THR_W'(cfg_i.floor_speed) * THR_W'(burst);
  assign acc_sum   = acc_q + ACC_W'(mag);
  assign fire      = acc_sum >= ACC_W'(threshold);
  assign pos_inc   = (pos_q == POS_LIMIT) ? pos_q : pos_q + POS_W'(1);

  always_comb begin
    acc_d  = acc_q;
    brem_d = brem_q;
    pos_d  = pos_q;
    on     = 1'b0;
    level  = '0;
    if (mag_raw == '0) begin
      acc_d  = '0;
      brem_d = '0;
      pos_d  = '0;
    end else if (cfg_i.floor_speed == '0 || mag >= cfg_i.floor_speed) begin
      level = mag;
      on    = 1'b1;
    end else if (brem_q != '0) begin
      level  = cfg_i.floor_speed;
      brem_d = brem_q - LEN_W'(1);
      on     = 1'b1;
    end else if (fire) begin
      acc_d  = acc_sum - ACC_W'(threshold);
      brem_d = burst - LEN_W'(1);
      level  = cfg_i.floor_speed;
      on     = 1'b1;
    end else begin
      acc_d = acc_sum;
      pos_d = '0;
    end
    if (on) begin
      pos_d = pos_inc;
      if (pos_inc <= POS_W'(cfg_i.kick_length) && cfg_i.boost_speed > level) begin
        level = cfg_i.boost_speed;
      end
    end
  end

  always_comb begin
    if (!on) begin
      command_o = '0;
    end else if (neg) begin
      command_o = -$signed({1'b0, level});
    end else begin
      command_o = $signed({1'b0, level});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      brem_q <= '0;
      pos_q  <= '0;
    end else if (clear_i) begin
      acc_q  <= '0;
      brem_q <= '0;
      pos_q  <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      brem_q <= brem_d;
      pos_q  <= pos_d;
    end
  end

  `KBPD_ASSERT(a_acc_below_thr,
               cfg_i.floor_speed == '0 || acc_q < ACC_W'(threshold), "acc at thr")
  `KBPD_ASSERT(a_brem_range, 32'(brem_q) < BURST_MAX, "burst count out of range")
  `KBPD_ASSERT_NEXT(a_zero_clears, step_i && !clear_i && mag_raw == '0,
                    acc_q == '0 && brem_q == '0 && pos_q == '0, "zero demand kept state")
  `KBPD_ASSERT_NEXT(a_on_moves_pos, step_i && !clear_i && command_o != '0,
                    pos_q != '0, "on tick without run position")

endmodule

`default_nettype wire

[rtl/kbpd_merge.sv]
`default_nettype none

module kbpd_merge
  import kbpd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic signed [CMD_W-1:0] left_i,
  input  wire logic signed [CMD_W-1:0] right_i,
  output logic                         ready_o,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [DATA_W-1:0]            m_axis_tdata
);

  logic              valid_q;
  logic [DATA_W-1:0] data_q;

  assign ready_o       = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= {{(DATA_W - 2 * CMD_W){1'b0}}, right_i, left_i};
    end
  end

endmodule

`default_nettype wire
